>>> hdl/tube_mesh_vertex_index_generator_macros.svh
// Assertion macros for the tube mesh vertex index generator.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef TUBE_MESH_VERTEX_INDEX_GENERATOR_MACROS_SVH
`define TUBE_MESH_VERTEX_INDEX_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TMVIG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TMVIG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/tmvig_pkg.sv
// Shared types, constants and the quarter-wave sine table of the tube mesh generator.
// No dependencies; every other file but tmvig_ram imports it.
package tmvig_pkg;

	localparam int SEG_W        = 11;
	localparam int MAX_SEGMENTS = 1024;
	localparam int SINE_D       = 1024;
	localparam int PH_W         = $clog2(4 * SINE_D);
	localparam int QR_W         = $clog2(SINE_D);
	localparam int TAB_AW       = $clog2(SINE_D + 1);
	localparam int TAB_W        = 15;
	localparam int NORM_ONE     = 16384;
	localparam int NORM_SH      = 14;
	localparam int POS_W        = 33;
	localparam int MAG_PW       = 32 + TAB_W;
	localparam int GRID_W       = 2 * (SEG_W + 1);

	// Divider: DIV_STEP quotient bits per cycle, over DIV_ITERS steps.
	localparam int DIV_STEP  = 7;
	localparam int DIV_ITERS = 7;
	localparam int NUM_W     = DIV_STEP * DIV_ITERS;
	localparam int ITER_W    = $clog2(DIV_ITERS);
	localparam int PROD_W    = SEG_W + 32;

	localparam int QUEUE_DEPTH = 2;

	// Tube parts
	localparam logic [1:0] ACT_OUTER = 2'd0;
	localparam logic [1:0] ACT_INNER = 2'd1;
	localparam logic [1:0] ACT_LOW   = 2'd2;
	localparam logic [1:0] ACT_HIGH  = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_INDEX  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_OUTER_RADIUS = 3'd0;
	localparam logic [2:0] CFG_INNER_RADIUS = 3'd1;
	localparam logic [2:0] CFG_TUBE_HEIGHT  = 3'd2;
	localparam logic [2:0] CFG_SEG_BASE     = 3'd3;
	localparam logic [2:0] CFG_SEG_HEIGHT   = 3'd4;
	localparam logic [2:0] CFG_U_TILE       = 3'd5;
	localparam logic [2:0] CFG_V_TILE       = 3'd6;
	localparam logic [2:0] CFG_BASE_OFFSET  = 3'd7;

	// Result tdata layout, lowest bit first
	localparam int OUT_IDX_LO = 210;
	localparam int OUT_DATA_W = 248;

	typedef struct packed {
		logic [31:0]      outer_radius;
		logic [31:0]      inner_radius;
		logic [31:0]      tube_height;
		logic [SEG_W-1:0] seg_base;
		logic [SEG_W-1:0] seg_height;
		logic [31:0]      u_tile;
		logic [31:0]      v_tile;
		logic [30:0]      base_offset;
	} cfg_t;

	// One classified item, ready for the result sequencer.
	typedef struct packed {
		logic             err;
		logic [1:0]       act;
		logic             has_tri;
		logic             cneg;
		logic             sneg;
		logic [TAB_W-1:0] mc;
		logic [TAB_W-1:0] ms;
		logic [POS_W-1:0] xi;
		logic [POS_W-1:0] zi;
		logic [POS_W-1:0] xo;
		logic [POS_W-1:0] zo;
		logic [31:0]      y;
		logic [31:0]      tu;
		logic [31:0]      tv0;
		logic [31:0]      tv1;
		logic [31:0]      i0;
	} job_t;

	typedef logic [TAB_W-1:0] sine_tab_t [0:SINE_D];

	// Quarter-wave sine in unsigned Q1.14, built at elaboration by a Taylor product.
	function automatic sine_tab_t build_sine();
		sine_tab_t       tab;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned one;
		one = 64'd1 << 30;
		for (int k = 0; k <= SINE_D; k++) begin
			x  = (longint'(k) * 64'h6487ED51 + SINE_D / 2) / SINE_D;
			x2 = (x * x) >> 30;
			t  = one;
			t  = one - ((x2 * t) >> 30) / 156;
			t  = one - ((x2 * t) >> 30) / 110;
			t  = one - ((x2 * t) >> 30) / 72;
			t  = one - ((x2 * t) >> 30) / 42;
			t  = one - ((x2 * t) >> 30) / 20;
			t  = one - ((x2 * t) >> 30) / 6;
			s  = (x * t) >> 30;
			s  = (s + 64'd32768) >> 16;
			if (s > NORM_ONE)
				s = NORM_ONE;
			tab[k] = s[TAB_W-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_Q = build_sine();

endpackage

>>> hdl/tmvig_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module tmvig_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

>>> hdl/tmvig_div.sv
// Iterative restoring divider, several quotient bits per cycle, narrow divisor.
// Depends on tmvig_pkg.
module tmvig_div import tmvig_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [SEG_W-1:0] divisor,
	input  logic             take,
	output logic             ready,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	logic              run_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [NUM_W-1:0]  n_q;
	logic [SEG_W:0]    rem_q;
	logic [SEG_W-1:0]  dvs_q;
	logic [NUM_W-1:0]  n_nx;
	logic [SEG_W:0]    rem_nx;

	assign ready = (!run_q && !done_q) || (done_q && take);
	assign done  = done_q;
	assign quot  = n_q;

	// shift in numerator bits, subtract where the partial remainder allows
	always_comb begin
		n_nx   = n_q;
		rem_nx = rem_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			rem_nx = {rem_nx[SEG_W-1:0], n_nx[NUM_W-1]};
			n_nx   = {n_nx[NUM_W-2:0], 1'b0};
			if (rem_nx >= {1'b0, dvs_q}) begin
				rem_nx  = rem_nx - {1'b0, dvs_q};
				n_nx[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start && ready) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ITER_W'(DIV_ITERS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (take) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && ready) begin
			n_q   <= numer;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			n_q   <= n_nx;
			rem_q <= rem_nx;
		end
	end

endmodule

>>> hdl/tmvig_queue.sv
// Short job queue between the classifying front and the result sequencer.
// Depends on tmvig_pkg.
module tmvig_queue import tmvig_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic push_rdy,
	input  logic pop,
	output logic head_v,
	output job_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_rdy = (cnt_q != (PTR_W + 1)'(QUEUE_DEPTH));
	assign head_v   = (cnt_q != '0);
	assign head     = mem_q[rd_q];
	assign do_push  = push && push_rdy;
	assign do_pop   = pop && head_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_job;
	end

endmodule

>>> hdl/tmvig_front.sv
// Front part: accepts items, range check, divisions, sine lookup, radius products.
// Depends on tmvig_pkg, tmvig_div and tmvig_ram.
module tmvig_front import tmvig_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_act,
	input  logic [SEG_W-1:0] in_ring,
	input  logic [SEG_W-1:0] in_seg,
	output logic             push,
	output job_t             push_job,
	input  logic             push_rdy
);

	// sine table fill after reset
	logic [TAB_AW-1:0] fill_q;
	logic              filled_q;

	// s0: accepted item
	logic             s0_v;
	logic [1:0]       act_s0;
	logic [SEG_W-1:0] ring_s0;
	logic [SEG_W-1:0] seg_s0;
	logic             s0_adv;
	logic             err_c;
	logic             tri_c;

	// s1: products and numerators
	logic             s1_v;
	logic [1:0]       act_s1;
	logic [SEG_W-1:0] seg_s1;
	logic             err_s1;
	logic             tri_s1;
	logic [GRID_W-1:0] rxs_s1;
	logic [GRID_W-1:0] hxs_s1;
	logic [NUM_W-1:0] nph_s1;
	logic [NUM_W-1:0] nu_s1;
	logic [NUM_W-1:0] ny_s1;
	logic [NUM_W-1:0] nv_s1;
	logic             s1_adv;

	// held beside the dividers
	logic [1:0]        act_q;
	logic [SEG_W-1:0]  seg_q;
	logic              err_q;
	logic              tri_q;
	logic [GRID_W-1:0] rxs_q;
	logic [GRID_W-1:0] hxs_q;

	logic [3:0]       dv_rdy;
	logic [3:0]       dv_done;
	logic [NUM_W-1:0] q_ph;
	logic [NUM_W-1:0] q_u;
	logic [NUM_W-1:0] q_y;
	logic [NUM_W-1:0] q_v;

	// s2: addresses issued, table data arriving
	logic             s2_v;
	logic             s2_ld;
	logic             s2_adv;
	logic [1:0]       act_s2;
	logic             err_s2;
	logic             tri_s2;
	logic             cneg_s2;
	logic             sneg_s2;
	logic [31:0]      y_s2;
	logic [31:0]      tu_s2;
	logic [31:0]      tv0_s2;
	logic [31:0]      tv1_s2;
	logic [31:0]      i0_s2;
	logic [PH_W-1:0]  ph_s;
	logic [PH_W-1:0]  ph_c;
	logic [TAB_AW-1:0] addr_s;
	logic [TAB_AW-1:0] addr_c;
	logic [TAB_W-1:0] tab_c;
	logic [TAB_W-1:0] tab_s;
	logic             wall_c;
	logic [31:0]      i0_c;
	logic [SEG_W:0]   sb1;

	// s3: radius products
	logic             s3_v;
	logic             s3_adv;
	logic [1:0]       act_s3;
	logic             err_s3;
	logic             tri_s3;
	logic             cneg_s3;
	logic             sneg_s3;
	logic [TAB_W-1:0] mc_s3;
	logic [TAB_W-1:0] ms_s3;
	logic [MAG_PW-1:0] xi_s3;
	logic [MAG_PW-1:0] zi_s3;
	logic [MAG_PW-1:0] xo_s3;
	logic [MAG_PW-1:0] zo_s3;
	logic [31:0]      y_s3;
	logic [31:0]      tu_s3;
	logic [31:0]      tv0_s3;
	logic [31:0]      tv1_s3;
	logic [31:0]      i0_s3;

	function automatic logic [TAB_AW-1:0] quarter_addr(input logic [PH_W-1:0] ph);
		logic [QR_W-1:0] r;
		r = ph[QR_W-1:0];
		return ph[QR_W] ? TAB_AW'(SINE_D) - TAB_AW'(r) : TAB_AW'(r);
	endfunction

	function automatic logic [POS_W-1:0] round_q14(input logic [MAG_PW-1:0] p);
		logic [MAG_PW:0] t;
		t = {1'b0, p} + (MAG_PW + 1)'(1 << (NORM_SH - 1));
		return t[NORM_SH+POS_W-1:NORM_SH];
	endfunction

	assign in_ready = filled_q && (!s0_v || s0_adv);
	assign s0_adv   = s0_v && (!s1_v || s1_adv);
	assign s1_adv   = s1_v && (&dv_rdy);
	assign s2_ld    = (&dv_done) && (!s2_v || s2_adv);
	assign s2_adv   = s2_v && (!s3_v || s3_adv);
	assign s3_adv   = s3_v && push_rdy;

	// table fill sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			filled_q <= 1'b0;
		end else if (!filled_q) begin
			fill_q <= fill_q + 1'b1;
			if (fill_q == TAB_AW'(SINE_D))
				filled_q <= 1'b1;
		end
	end

	// range check of the accepted item
	always_comb begin
		err_c = (cfg.seg_base == '0) || (cfg.seg_height == '0) ||
			(cfg.seg_base > SEG_W'(MAX_SEGMENTS)) ||
			(cfg.seg_height > SEG_W'(MAX_SEGMENTS)) ||
			(seg_s0 > cfg.seg_base) ||
			(!act_s0[1] && (ring_s0 > cfg.seg_height));
		tri_c = act_s0[1] ? (seg_s0 < cfg.seg_base) : (ring_s0 < cfg.seg_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_v <= 1'b0;
			s1_v <= 1'b0;
			s2_v <= 1'b0;
			s3_v <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				s0_v <= 1'b1;
			else if (s0_adv)
				s0_v <= 1'b0;
			if (s0_adv)
				s1_v <= 1'b1;
			else if (s1_adv)
				s1_v <= 1'b0;
			if (s2_ld)
				s2_v <= 1'b1;
			else if (s2_adv)
				s2_v <= 1'b0;
			if (s2_adv)
				s3_v <= 1'b1;
			else if (s3_adv)
				s3_v <= 1'b0;
		end
	end

	assign sb1 = {1'b0, cfg.seg_base} + 1'b1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_s0  <= in_act;
			ring_s0 <= in_ring;
			seg_s0  <= in_seg;
		end
		if (s0_adv) begin
			act_s1 <= act_s0;
			seg_s1 <= seg_s0;
			err_s1 <= err_c;
			tri_s1 <= tri_c;
			rxs_s1 <= GRID_W'(ring_s0) * GRID_W'(sb1);
			hxs_s1 <= GRID_W'({1'b0, cfg.seg_height} + 1'b1) * GRID_W'(sb1);
			nph_s1 <= NUM_W'({seg_s0, {PH_W{1'b0}}}) + NUM_W'(cfg.seg_base[SEG_W-1:1]);
			nu_s1  <= NUM_W'(PROD_W'(seg_s0) * PROD_W'(cfg.u_tile)) +
				NUM_W'(cfg.seg_base[SEG_W-1:1]);
			ny_s1  <= NUM_W'(PROD_W'(ring_s0) * PROD_W'(cfg.tube_height)) +
				NUM_W'(cfg.seg_height[SEG_W-1:1]);
			nv_s1  <= NUM_W'(PROD_W'(ring_s0) * PROD_W'(cfg.v_tile)) +
				NUM_W'(cfg.seg_height[SEG_W-1:1]);
		end
		if (s1_adv) begin
			act_q <= act_s1;
			seg_q <= seg_s1;
			err_q <= err_s1;
			tri_q <= tri_s1;
			rxs_q <= rxs_s1;
			hxs_q <= hxs_s1;
		end
	end

	tmvig_div u_div_ph (
		.clk(clk), .arst_n(arst_n), .start(s1_adv), .numer(nph_s1),
		.divisor(cfg.seg_base), .take(s2_ld), .ready(dv_rdy[0]),
		.done(dv_done[0]), .quot(q_ph)
	);
	tmvig_div u_div_u (
		.clk(clk), .arst_n(arst_n), .start(s1_adv), .numer(nu_s1),
		.divisor(cfg.seg_base), .take(s2_ld), .ready(dv_rdy[1]),
		.done(dv_done[1]), .quot(q_u)
	);
	tmvig_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(s1_adv), .numer(ny_s1),
		.divisor(cfg.seg_height), .take(s2_ld), .ready(dv_rdy[2]),
		.done(dv_done[2]), .quot(q_y)
	);
	tmvig_div u_div_v (
		.clk(clk), .arst_n(arst_n), .start(s1_adv), .numer(nv_s1),
		.divisor(cfg.seg_height), .take(s2_ld), .ready(dv_rdy[3]),
		.done(dv_done[3]), .quot(q_v)
	);

	// phase folds onto the quarter table; cosine leads by a quarter turn
	assign ph_s   = q_ph[PH_W-1:0];
	assign ph_c   = ph_s + PH_W'(SINE_D);
	assign addr_s = quarter_addr(ph_s);
	assign addr_c = quarter_addr(ph_c);
	assign wall_c = !act_q[1];

	always_comb begin
		if (wall_c)
			i0_c = 32'(cfg.base_offset) + ((act_q == ACT_INNER) ? 32'(hxs_q) : 32'd0) +
				32'(rxs_q) + 32'(seg_q);
		else
			i0_c = 32'(cfg.base_offset) + 32'({hxs_q, 1'b0}) +
				((act_q == ACT_HIGH) ? 32'({sb1, 1'b0}) : 32'd0) + 32'({seg_q, 1'b0});
	end

	tmvig_ram #(
		.WIDTH(TAB_W),
		.DEPTH(SINE_D + 1)
	) u_sine (
		.clk(clk),
		.we(!filled_q),
		.waddr(fill_q),
		.wdata(SINE_Q[fill_q]),
		.re(s2_ld),
		.raddr_a(addr_c),
		.raddr_b(addr_s),
		.rdata_a(tab_c),
		.rdata_b(tab_s)
	);

	always_ff @(posedge clk) begin
		if (s2_ld) begin
			act_s2  <= act_q;
			err_s2  <= err_q;
			tri_s2  <= tri_q;
			cneg_s2 <= ph_c[PH_W-1];
			sneg_s2 <= ph_s[PH_W-1];
			tu_s2   <= q_u[31:0];
			i0_s2   <= i0_c;
			if (wall_c) begin
				y_s2   <= q_y[31:0];
				tv0_s2 <= q_v[31:0];
			end else begin
				y_s2   <= (act_q == ACT_HIGH) ? cfg.tube_height : 32'd0;
				tv0_s2 <= (act_q == ACT_HIGH) ? 32'd0 : cfg.v_tile;
			end
			tv1_s2 <= (act_q == ACT_HIGH) ? cfg.v_tile : 32'd0;
		end
		if (s2_adv) begin
			act_s3  <= act_s2;
			err_s3  <= err_s2;
			tri_s3  <= tri_s2;
			cneg_s3 <= cneg_s2;
			sneg_s3 <= sneg_s2;
			mc_s3   <= tab_c;
			ms_s3   <= tab_s;
			xi_s3   <= MAG_PW'(cfg.inner_radius) * MAG_PW'(tab_c);
			zi_s3   <= MAG_PW'(cfg.inner_radius) * MAG_PW'(tab_s);
			xo_s3   <= MAG_PW'(cfg.outer_radius) * MAG_PW'(tab_c);
			zo_s3   <= MAG_PW'(cfg.outer_radius) * MAG_PW'(tab_s);
			y_s3    <= y_s2;
			tu_s3   <= tu_s2;
			tv0_s3  <= tv0_s2;
			tv1_s3  <= tv1_s2;
			i0_s3   <= i0_s2;
		end
	end

	assign push = s3_v;

	always_comb begin
		push_job.err     = err_s3;
		push_job.act     = act_s3;
		push_job.has_tri = tri_s3;
		push_job.cneg    = cneg_s3;
		push_job.sneg    = sneg_s3;
		push_job.mc      = mc_s3;
		push_job.ms      = ms_s3;
		push_job.xi      = round_q14(xi_s3);
		push_job.zi      = round_q14(zi_s3);
		push_job.xo      = round_q14(xo_s3);
		push_job.zo      = round_q14(zo_s3);
		push_job.y       = y_s3;
		push_job.tu      = tu_s3;
		push_job.tv0     = tv0_s3;
		push_job.tv1     = tv1_s3;
		push_job.i0      = i0_s3;
	end

endmodule

>>> hdl/tmvig_back.sv
// Back part: walks one job into vertex, triangle index or error records, one per cycle while out_ready is high.
// Depends on tmvig_pkg.
module tmvig_back import tmvig_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  head_v,
	input  job_t                  head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            out_kind,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_last
);

	localparam int TRI_N = 6;

	// triangle corner offsets from the first vertex index
	localparam logic [2:0] OFF_ZERO  = 3'd0;
	localparam logic [2:0] OFF_ONE   = 3'd1;
	localparam logic [2:0] OFF_TWO   = 3'd2;
	localparam logic [2:0] OFF_THREE = 3'd3;
	localparam logic [2:0] OFF_S     = 3'd4;
	localparam logic [2:0] OFF_S1    = 3'd5;

	logic [2:0]  step_q;
	logic        valid_q;
	logic [1:0]  kind_q;
	logic [OUT_DATA_W-1:0] data_q;
	logic        last_q;

	logic        ld;
	logic        cap;
	logic        second;
	logic        use_outer;
	logic [2:0]  nv;
	logic [2:0]  last_step;
	logic [2:0]  k;
	logic [2:0]  code;
	logic [31:0] off;
	logic [POS_W-1:0] mx;
	logic [POS_W-1:0] mz;
	logic [15:0] cs;
	logic [15:0] sn;
	logic [POS_W-1:0] px;
	logic [31:0] py;
	logic [POS_W-1:0] pz;
	logic [15:0] nx;
	logic [15:0] ny;
	logic [15:0] nz;
	logic [31:0] tv;
	logic [31:0] idx;
	logic [1:0]  kind_c;

	function automatic logic [2:0] off_code(input logic [1:0] act, input logic [2:0] n);
		logic [2:0] c;
		c = OFF_ZERO;
		case (act)
			ACT_OUTER: case (n)
				3'd0, 3'd3: c = OFF_S1;
				3'd2:       c = OFF_S;
				3'd4:       c = OFF_ONE;
				default:    c = OFF_ZERO;
			endcase
			ACT_INNER: case (n)
				3'd0, 3'd3: c = OFF_S1;
				3'd1:       c = OFF_S;
				3'd5:       c = OFF_ONE;
				default:    c = OFF_ZERO;
			endcase
			ACT_LOW: case (n)
				3'd1:       c = OFF_ONE;
				3'd2, 3'd5: c = OFF_THREE;
				3'd3:       c = OFF_TWO;
				default:    c = OFF_ZERO;
			endcase
			default: case (n)
				3'd0:       c = OFF_ONE;
				3'd2, 3'd5: c = OFF_THREE;
				3'd4:       c = OFF_TWO;
				default:    c = OFF_ZERO;
			endcase
		endcase
		return c;
	endfunction

	assign ld  = head_v && (!valid_q || out_ready);
	assign cap = head.act[1];
	assign nv  = cap ? 3'd2 : 3'd1;
	assign last_step = head.err ? 3'd0 : (nv - 1'b1 + (head.has_tri ? 3'(TRI_N) : 3'd0));
	assign pop = ld && (step_q == last_step);
	assign second = cap && (step_q == 3'd1);
	assign use_outer = (head.act == ACT_OUTER) || second;
	assign k = step_q - nv;
	assign code = off_code(head.act, k);

	always_comb begin
		case (code)
			OFF_ONE:   off = 32'd1;
			OFF_TWO:   off = 32'd2;
			OFF_THREE: off = 32'd3;
			OFF_S:     off = 32'(cfg.seg_base);
			OFF_S1:    off = 32'(cfg.seg_base) + 32'd1;
			default:   off = 32'd0;
		endcase
	end

	// build one record from the job at the queue head
	always_comb begin
		mx = use_outer ? head.xo : head.xi;
		mz = use_outer ? head.zo : head.zi;
		cs = head.cneg ? -{1'b0, head.mc} : {1'b0, head.mc};
		sn = head.sneg ? -{1'b0, head.ms} : {1'b0, head.ms};
		px = '0; py = '0; pz = '0; nx = '0; ny = '0; nz = '0;
		tv = '0; idx = '0;
		if (head.err) begin
			kind_c = KIND_ERROR;
		end else if (step_q < nv) begin
			kind_c = KIND_VERTEX;
			px  = head.cneg ? -mx : mx;
			pz  = head.sneg ? -mz : mz;
			py  = head.y;
			tv  = second ? head.tv1 : head.tv0;
			idx = head.i0 + (second ? 32'd1 : 32'd0);
			if (cap) begin
				ny = (head.act == ACT_HIGH) ? 16'(NORM_ONE) : -16'(NORM_ONE);
			end else if (head.act == ACT_INNER) begin
				nx = -cs;
				nz = -sn;
			end else begin
				nx = cs;
				nz = sn;
			end
		end else begin
			kind_c = KIND_INDEX;
			idx    = head.i0 + off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (ld)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
			if (pop)
				step_q <= '0;
			else if (ld)
				step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			kind_q <= kind_c;
			last_q <= (step_q == last_step);
			data_q <= {6'd0, idx, tv,
				(kind_c == KIND_VERTEX) ? head.tu : 32'd0,
				nz, ny, nx, pz, py, px};
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_data  = data_q;
	assign out_last  = last_q;

endmodule

>>> hdl/tube_mesh_vertex_index_generator.sv
// Top level of the tube mesh vertex index generator: ports, configuration registers,
// and the front / queue / back split. Depends on tmvig_pkg, tmvig_front, tmvig_queue,
// tmvig_back (and through them tmvig_div, tmvig_ram).
//
//  Channel   Direction  Handshake          Carries
//  s_        in         s_tvalid/s_tready  tuser action; tdata ring, segment
//  m_        out        m_tvalid/m_tready  tuser kind; tdata vertex or index; tlast
//  cfg_      in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// An item passes through the four-lane divider (7 quotient bits a cycle), which takes a new
// item only once the last quotients are taken; the back emits one record a cycle while
// m_tready is high, 1 to 8 per item.
// After reset the sine table is written, all 1025 entries; s_tready stays low meanwhile.
// The two-entry job queue lets the front run on while the result side is stalled.
module tube_mesh_vertex_index_generator import tmvig_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // ring[10:0], segment[21:11], zero pad
	input  logic [1:0]            s_tuser,   // action[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // pos_x[32:0], pos_y[64:33], pos_z[97:65],
	                                         // norm_x[113:98], norm_y[129:114],
	                                         // norm_z[145:130], tex_u[177:146],
	                                         // tex_v[209:178], index_value[241:210], pad
	output logic [1:0]            m_tuser,   // kind[1:0]
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	cfg_t cfg_q;
	logic push;
	logic push_rdy;
	job_t push_job;
	logic pop;
	logic head_v;
	job_t head;

	// Registers take any write; configuration should only change while idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outer_radius <= 32'd65536;
			cfg_q.inner_radius <= 32'd32768;
			cfg_q.tube_height  <= 32'd65536;
			cfg_q.seg_base     <= SEG_W'(16);
			cfg_q.seg_height   <= SEG_W'(1);
			cfg_q.u_tile       <= 32'd65536;
			cfg_q.v_tile       <= 32'd65536;
			cfg_q.base_offset  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OUTER_RADIUS: cfg_q.outer_radius <= cfg_data;
				CFG_INNER_RADIUS: cfg_q.inner_radius <= cfg_data;
				CFG_TUBE_HEIGHT:  cfg_q.tube_height  <= cfg_data;
				CFG_SEG_BASE:     cfg_q.seg_base     <= cfg_data[SEG_W-1:0];
				CFG_SEG_HEIGHT:   cfg_q.seg_height   <= cfg_data[SEG_W-1:0];
				CFG_U_TILE:       cfg_q.u_tile       <= cfg_data;
				CFG_V_TILE:       cfg_q.v_tile       <= cfg_data;
				CFG_BASE_OFFSET:  cfg_q.base_offset  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Front: accept, classify, divide, look up the sine, scale by the radii.
	tmvig_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_act(s_tuser),
		.in_ring(s_tdata[10:0]),
		.in_seg(s_tdata[21:11]),
		.push(push),
		.push_job(push_job),
		.push_rdy(push_rdy)
	);

	// Hold finished jobs between the two halves.
	tmvig_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.push_rdy(push_rdy),
		.pop(pop),
		.head_v(head_v),
		.head(head)
	);

	// Back: transfer the records of the head job, drop it after its last one.
	tmvig_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head_v(head_v),
		.head(head),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind(m_tuser),
		.out_data(m_tdata),
		.out_last(m_tlast)
	);

endmodule

>>> hdl/tmvig_checker.sv
// Port-level checks for the tube mesh vertex index generator, bound to the top level.
// Depends on tmvig_pkg and tube_mesh_vertex_index_generator_macros.svh.
`include "tube_mesh_vertex_index_generator_macros.svh"

module tmvig_checker import tmvig_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]            m_tuser,
	input logic                  m_tlast
);

	`TMVIG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`TMVIG_ASSERT_NOW(a_err_last, m_tvalid && (m_tuser == KIND_ERROR), m_tlast && (m_tdata == '0), "error record not alone")
	`TMVIG_ASSERT_NOW(a_idx_clean, m_tvalid && (m_tuser == KIND_INDEX), m_tdata[OUT_IDX_LO-1:0] == '0, "index record carries vertex data")
	`TMVIG_ASSERT_NEXT(a_idx_run, m_tvalid && m_tready && (m_tuser == KIND_INDEX) && !m_tlast, m_tvalid && (m_tuser == KIND_INDEX), "triangle run broken")

endmodule

bind tube_mesh_vertex_index_generator tmvig_checker u_chk (.*);
